FILE: rtl/mtbf_pkg.sv
// Shared types, widths and register codes of the multi-table Bloom filter.
package mtbf_pkg;

   localparam int HASH_W      = 64;
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_COUNT = HASH_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGIT_COUNT);
   localparam int SIZE_W      = 17;
   localparam int TCOUNT_W    = 3;
   localparam int UNIQUE_W    = 32;
   localparam int BYTE_W      = 8;
   localparam int BYTE_SHIFT  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int SIZE_SLOTS  = 4;

   localparam logic [TCOUNT_W-1:0] TABLE_COUNT_RESET = 3'd4;
   localparam logic [SIZE_W-1:0]   SIZE_ZERO_RESET   = 17'd65521;
   localparam logic [SIZE_W-1:0]   SIZE_ONE_RESET    = 17'd65519;
   localparam logic [SIZE_W-1:0]   SIZE_TWO_RESET    = 17'd65497;
   localparam logic [SIZE_W-1:0]   SIZE_THREE_RESET  = 17'd65479;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_QUERY  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      REG_TABLE_COUNT = 3'd0,
      REG_SIZE_ZERO   = 3'd1,
      REG_SIZE_ONE    = 3'd2,
      REG_SIZE_TWO    = 3'd3,
      REG_SIZE_THREE  = 3'd4
   } csr_index_type;

endpackage

FILE: rtl/mtbf_intf.sv
// Request and response channel interfaces of the multi-table Bloom filter.
interface mtbf_req_intf
   import mtbf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [HASH_W-1:0] hash_value;

   modport source (output valid, mode, hash_value, input ready);
   modport sink   (input valid, mode, hash_value, output ready);
endinterface

interface mtbf_rsp_intf
   import mtbf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                present;
   logic [SIZE_W-1:0]   occupied_bins;
   logic [UNIQUE_W-1:0] unique_items;

   modport source (output valid, present, occupied_bins, unique_items, input ready);
   modport sink   (input valid, present, occupied_bins, unique_items, output ready);
endinterface

FILE: rtl/mtbf_ram.sv
// Generic simple dual-port RAM with registered read data.
module mtbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/multi_table_bloom_filter_unit.sv
// Top level of the multi-table Bloom presence filter.
//
//  port group   direction  handshake              payload
//  req_bus      in         valid/ready            mode, hash_value
//  rsp_bus      out        valid/ready            present, occupied_bins, unique_items
//  apb (p*)     in         psel/penable, pready=1 paddr, pwdata, prdata
//
// A request is taken in the idle state. The radix-16 remainder lanes then step through
// every hex digit of the hash, then each active table gets a read and a check/write
// step on the single bit-store RAM, then the response register is loaded and the block
// returns to idle, where the next request is taken.
// After reset a clearing pass writes zero to every byte of the bit store, one byte a
// cycle, over ceil(NUM_TABLES*MAX_TABLE_BITS/8) bytes (32768 at the defaults). No request
// is taken during it; register writes are.
// A stalled response holds in its register; the next request is taken meanwhile and
// waits in its final cycle only if the previous response is still unclaimed.
module multi_table_bloom_filter_unit
   import mtbf_pkg::*;
#(
   parameter int NUM_TABLES     = 4,
   parameter int MAX_TABLE_BITS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   mtbf_req_intf.sink            req_bus,
   mtbf_rsp_intf.source          rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // bit position space: table t occupies [t*MAX_TABLE_BITS, (t+1)*MAX_TABLE_BITS)
   localparam int TOTAL_BITS = NUM_TABLES * MAX_TABLE_BITS;
   localparam int POS_W      = $clog2(TOTAL_BITS);
   localparam int MEM_DEPTH  = (TOTAL_BITS + BYTE_W - 1) / BYTE_W;
   localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int unsigned MAX_BITS = MAX_TABLE_BITS;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DIVIDE = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   // One radix-16 step of the remainder: four restoring compare-subtract bits.
   function automatic logic [SIZE_W-1:0] mod_digit(
      input logic [SIZE_W-1:0]  rem,
      input logic [DIGIT_W-1:0] digit,
      input logic [SIZE_W-1:0]  size
   );
      logic [SIZE_W:0]   acc;
      logic [SIZE_W-1:0] r;
      r = rem;
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
         acc = {r, digit[k]};
         if (acc >= {1'b0, size}) begin
            acc = acc - {1'b0, size};
         end
         r = acc[SIZE_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   state_type             state_ff, state_in;
   logic [TCOUNT_W-1:0]   table_count_ff, table_count_in;
   logic [SIZE_W-1:0]     size_ff [SIZE_SLOTS];
   logic [SIZE_W-1:0]     size_in [SIZE_SLOTS];
   logic [SIZE_W-1:0]     occupied_ff, occupied_in;
   logic [UNIQUE_W-1:0]   unique_ff, unique_in;
   logic [ADDR_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [DIGIT_CNT_W-1:0] digit_cnt_ff, digit_cnt_in;
   logic [TBL_W-1:0]      tbl_ff, tbl_in;
   logic                  all_set_ff, all_set_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers, no reset
   mode_type              mode_ff, mode_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [SIZE_W-1:0]     rem_ff [NUM_TABLES];
   logic [SIZE_W-1:0]     rem_in [NUM_TABLES];
   logic                  present_ff, present_in;
   logic [SIZE_W-1:0]     occ_out_ff, occ_out_in;
   logic [UNIQUE_W-1:0]   uniq_out_ff, uniq_out_in;

   // ---------------------------------------------------------------- derived
   logic [TCOUNT_W-1:0]   active_n;
   logic [TCOUNT_W-1:0]   last_tbl;
   logic [SIZE_W-1:0]     eff_size [NUM_TABLES];
   logic [POS_W-1:0]      pos_lane [NUM_TABLES];
   logic [POS_W-1:0]      pos_sel;
   logic [ADDR_W-1:0]     acc_addr;
   logic [BYTE_SHIFT-1:0] bit_sel;
   logic                  was_set;
   logic                  req_fire;
   logic                  csr_write;
   csr_index_type         csr_idx;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0]     mem_wr_data;
   logic                  mem_rd_en;
   logic [BYTE_W-1:0]     mem_rd_data;

   // Zero count means one table; above the built count it saturates.
   always_comb begin
      if (table_count_ff == '0) begin
         active_n = TCOUNT_W'(1);
      end else if (table_count_ff > TCOUNT_W'(NUM_TABLES)) begin
         active_n = TCOUNT_W'(NUM_TABLES);
      end else begin
         active_n = table_count_ff;
      end
   end

   assign last_tbl = active_n - TCOUNT_W'(1);

   // Per-table lane: effective modulus, remainder bit position.
   for (genvar t = 0; t < NUM_TABLES; t++) begin : g_lane
      localparam int unsigned BASE = t * MAX_TABLE_BITS;
      logic [POS_W+SIZE_W-1:0] pos_wide;

      always_comb begin
         if (size_ff[t] == '0) begin
            eff_size[t] = SIZE_W'(1);
         end else if (32'(size_ff[t]) > MAX_BITS) begin
            eff_size[t] = SIZE_W'(MAX_BITS);
         end else begin
            eff_size[t] = size_ff[t];
         end
      end

      assign pos_wide    = (POS_W+SIZE_W)'(BASE) + (POS_W+SIZE_W)'(rem_ff[t]);
      assign pos_lane[t] = pos_wide[POS_W-1:0];
   end

   assign pos_sel  = pos_lane[tbl_ff];
   assign acc_addr = ADDR_W'(pos_sel >> BYTE_SHIFT);
   assign bit_sel  = pos_sel[BYTE_SHIFT-1:0];
   assign was_set  = mem_rd_data[bit_sel];

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_idx   = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      table_count_in = table_count_ff;
      for (int i = 0; i < SIZE_SLOTS; i++) begin
         size_in[i] = size_ff[i];
      end
      if (csr_write) begin
         unique case (csr_idx)
            REG_TABLE_COUNT: table_count_in = pwdata[TCOUNT_W-1:0];
            REG_SIZE_ZERO:   size_in[0]     = pwdata[SIZE_W-1:0];
            REG_SIZE_ONE:    size_in[1]     = pwdata[SIZE_W-1:0];
            REG_SIZE_TWO:    size_in[2]     = pwdata[SIZE_W-1:0];
            REG_SIZE_THREE:  size_in[3]     = pwdata[SIZE_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TABLE_COUNT: prdata = CSR_DATA_W'(table_count_ff);
         REG_SIZE_ZERO:   prdata = CSR_DATA_W'(size_ff[0]);
         REG_SIZE_ONE:    prdata = CSR_DATA_W'(size_ff[1]);
         REG_SIZE_TWO:    prdata = CSR_DATA_W'(size_ff[2]);
         REG_SIZE_THREE:  prdata = CSR_DATA_W'(size_ff[3]);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.present       = present_ff;
   assign rsp_bus.occupied_bins = occ_out_ff;
   assign rsp_bus.unique_items  = uniq_out_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      occupied_in   = occupied_ff;
      unique_in     = unique_ff;
      clear_addr_in = clear_addr_ff;
      digit_cnt_in  = digit_cnt_ff;
      tbl_in        = tbl_ff;
      all_set_in    = all_set_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      hash_in       = hash_ff;
      for (int t = 0; t < NUM_TABLES; t++) begin
         rem_in[t] = rem_ff[t];
      end
      present_in    = present_ff;
      occ_out_in    = occ_out_ff;
      uniq_out_in   = uniq_out_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = acc_addr;
      mem_wr_data   = mem_rd_data | (BYTE_W'(1) << bit_sel);
      mem_rd_en     = 1'b0;

      // a taken response frees the output register
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the bit store with zeros, one byte a cycle
            mem_wr_en     = 1'b1;
            mem_wr_addr   = clear_addr_ff;
            mem_wr_data   = '0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in      = mode_type'(req_bus.mode);
               hash_in      = req_bus.hash_value;
               digit_cnt_in = '0;
               all_set_in   = 1'b1;
               for (int t = 0; t < NUM_TABLES; t++) begin
                  rem_in[t] = '0;
               end
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            // advance every lane by the top hex digit of the hash
            for (int t = 0; t < NUM_TABLES; t++) begin
               rem_in[t] = mod_digit(rem_ff[t], hash_ff[HASH_W-1 -: DIGIT_W], eff_size[t]);
            end
            hash_in      = hash_ff << DIGIT_W;
            digit_cnt_in = digit_cnt_ff + DIGIT_CNT_W'(1);
            if (digit_cnt_ff == DIGIT_CNT_W'(DIGIT_COUNT - 1)) begin
               tbl_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (!was_set) begin
               all_set_in = 1'b0;
               if (mode_ff == MODE_INSERT) begin
                  mem_wr_en = 1'b1;
                  if (tbl_ff == '0 && occupied_ff != '1) begin
                     occupied_in = occupied_ff + SIZE_W'(1);
                  end
               end
            end
            if (TCOUNT_W'(tbl_ff) == last_tbl) begin
               state_in = S_DONE;
            end else begin
               tbl_in   = tbl_ff + TBL_W'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            // hold here while the previous response is still unclaimed
            if (!rsp_valid_ff || rsp_bus.ready) begin
               if (mode_ff == MODE_INSERT && !all_set_ff && unique_ff != '1) begin
                  unique_in = unique_ff + UNIQUE_W'(1);
               end
               present_in   = all_set_ff;
               occ_out_in   = occupied_ff;
               uniq_out_in  = unique_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         table_count_ff <= TABLE_COUNT_RESET;
         size_ff[0]     <= SIZE_ZERO_RESET;
         size_ff[1]     <= SIZE_ONE_RESET;
         size_ff[2]     <= SIZE_TWO_RESET;
         size_ff[3]     <= SIZE_THREE_RESET;
         occupied_ff    <= '0;
         unique_ff      <= '0;
         clear_addr_ff  <= '0;
         digit_cnt_ff   <= '0;
         tbl_ff         <= '0;
         all_set_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_count_ff <= table_count_in;
         for (int i = 0; i < SIZE_SLOTS; i++) begin
            size_ff[i] <= size_in[i];
         end
         occupied_ff    <= occupied_in;
         unique_ff      <= unique_in;
         clear_addr_ff  <= clear_addr_in;
         digit_cnt_ff   <= digit_cnt_in;
         tbl_ff         <= tbl_in;
         all_set_ff     <= all_set_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      hash_ff     <= hash_in;
      for (int t = 0; t < NUM_TABLES; t++) begin
         rem_ff[t] <= rem_in[t];
      end
      present_ff  <= present_in;
      occ_out_ff  <= occ_out_in;
      uniq_out_ff <= uniq_out_in;
   end

   // ---------------------------------------------------------------- bit store
   mtbf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MEM_DEPTH)
   ) u_bits (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (acc_addr),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------- assertions
   // A query never writes the bit store outside the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff != S_CLEAR) |-> (mode_ff == MODE_INSERT))
      else $error("bit store written during a query");

   // The unique count moves only when a response is loaded.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(unique_ff))
      else $error("unique count changed outside the response cycle");

   // The table walk never passes the active table count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CHECK) |-> (TCOUNT_W'(tbl_ff) <= last_tbl))
      else $error("table index beyond the active tables");

   // A query step leaves the occupied count alone.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && mode_ff == MODE_QUERY) |=> $stable(occupied_ff))
      else $error("occupied count changed by a query");

endmodule

FILE: tb/tb_multi_table_bloom_filter_unit.sv
// Self-checking testbench of the multi-table Bloom presence filter.
module tb_multi_table_bloom_filter_unit;
   import mtbf_pkg::*;

   localparam int TB_TABLES       = 4;
   localparam int TB_TABLE_BITS   = 65536;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 8;
   localparam int REG_STRIDE      = 4;
   localparam int REG_COUNT       = 5;
   localparam int REG_BEYOND_LAST = 5;
   localparam int RAND_PHASES     = 10;
   localparam int PHASE_REQUESTS  = 183;
   localparam int HOLD_PHASE      = 3;
   localparam int LONG_HOLD       = 400;
   localparam int MAX_BURST       = 12;
   localparam int HASH_POOL_DEPTH = 64;
   localparam int TAIL_CYCLES     = 40;
   localparam int MAX_REPORTS     = 10;
   // The clearing pass after reset alone runs without a handshake.
   localparam int IDLE_LIMIT      = 200000;

   localparam logic [SIZE_W-1:0]   OCC_MAX    = '1;
   localparam logic [UNIQUE_W-1:0] UNIQUE_MAX = '1;

   typedef struct packed {
      logic                present;
      logic [SIZE_W-1:0]   occupied_bins;
      logic [UNIQUE_W-1:0] unique_items;
   } filter_result_type;

   // One row of the directed table: a register write or a request.
   typedef struct {
      bit                is_write;
      int unsigned       reg_idx;
      logic [31:0]       reg_value;
      mode_type          mode;
      logic [63:0]       hash;
      bit                typed;
      filter_result_type typed_result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   mtbf_req_intf req_bus();
   mtbf_rsp_intf rsp_bus();

   multi_table_bloom_filter_unit #(
      .NUM_TABLES    (TB_TABLES),
      .MAX_TABLE_BITS(TB_TABLE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   // Shadow filter: bit tables, counters and register copies.
   bit                  filter_shadow [TB_TABLES][TB_TABLE_BITS];
   logic [SIZE_W-1:0]   occupied_shadow;
   logic [UNIQUE_W-1:0] unique_shadow;
   logic [TCOUNT_W-1:0] table_count_shadow;
   logic [SIZE_W-1:0]   table_size_shadow [SIZE_SLOTS];

   filter_result_type pending_results[$];
   stim_row_type      directed_rows[$];
   logic [63:0]       seen_hashes[$];

   int mismatch_count;
   int idle_cycles;
   int hold_requests;
   int hold_served;
   int hold_left;
   int stall_left;
   bit quiet;
   filter_result_type response_want;

   always #HALF_PERIOD clock = ~clock;

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %0s: expected %0h actual %0h", what, want, got);
   endtask

   // Test the addressed bin of every active table and, on an insert, set it, as the block does.
   function automatic filter_result_type filter_predict(input mode_type m,
                                                        input logic [63:0] h);
      int unsigned       active;
      logic [63:0]       modulus;
      int unsigned       bin;
      bit                all_set;
      filter_result_type r;
      active = (table_count_shadow == 0) ? 1 :
               (table_count_shadow > TB_TABLES) ? TB_TABLES : table_count_shadow;
      all_set = 1'b1;
      for (int t = 0; t < active; t++) begin
         modulus = (table_size_shadow[t] == 0) ? 64'd1 :
                   (table_size_shadow[t] > TB_TABLE_BITS) ? 64'(TB_TABLE_BITS) :
                   64'(table_size_shadow[t]);
         bin = int'(h % modulus);
         if (!filter_shadow[t][bin]) begin
            all_set = 1'b0;
            if (m == MODE_INSERT) begin
               filter_shadow[t][bin] = 1'b1;
               if (t == 0 && occupied_shadow < OCC_MAX) occupied_shadow++;
            end
         end
      end
      if (m == MODE_INSERT && !all_set && unique_shadow < UNIQUE_MAX) unique_shadow++;
      r.present       = all_set;
      r.occupied_bins = occupied_shadow;
      r.unique_items  = unique_shadow;
      return r;
   endfunction

   // Offer one request, hold it until taken, then log what it must return.
   task automatic send_request(input mode_type m, input logic [63:0] h, input bit typed,
                               input filter_result_type typed_result);
      filter_result_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.hash_value <= h;
      do @(posedge clock); while (!req_bus.ready);
      predicted = filter_predict(m, h);
      pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
      if (m == MODE_INSERT) begin
         seen_hashes.insert(seen_hashes.size(), h);
         if (seen_hashes.size() > HASH_POOL_DEPTH) void'(seen_hashes.pop_front());
      end
   endtask

   // Drop valid and wait until every outstanding response has been claimed.
   task automatic drain_filter();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_read(input int unsigned idx, output logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(idx * REG_STRIDE);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write one register, track it, then read back the whole register file.
   task automatic csr_write(input int unsigned idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx * REG_STRIDE);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_TABLE_COUNT: table_count_shadow = value[TCOUNT_W-1:0];
         REG_SIZE_ZERO, REG_SIZE_ONE, REG_SIZE_TWO, REG_SIZE_THREE:
            table_size_shadow[idx - 1] = value[SIZE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      for (int r = 0; r < REG_COUNT; r++) begin
         csr_read(r, readback);
         @(posedge clock);
         if (r == REG_TABLE_COUNT) begin
            want = CSR_DATA_W'(table_count_shadow);
            readback = readback & CSR_DATA_W'({TCOUNT_W{1'b1}});
         end else begin
            want = CSR_DATA_W'(table_size_shadow[r - 1]);
            readback = readback & CSR_DATA_W'({SIZE_W{1'b1}});
         end
         if (readback !== want) note_mismatch($sformatf("register %0d", r), want, readback);
      end
   endtask

   function automatic void add_request(input mode_type m, input logic [63:0] h);
      stim_row_type row;
      row.is_write     = 1'b0;
      row.reg_idx      = 0;
      row.reg_value    = '0;
      row.mode         = m;
      row.hash         = h;
      row.typed        = 1'b0;
      row.typed_result = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void add_checked(input mode_type m, input logic [63:0] h,
                                       input logic p, input logic [SIZE_W-1:0] occ,
                                       input logic [UNIQUE_W-1:0] uniq);
      add_request(m, h);
      directed_rows[$].typed        = 1'b1;
      directed_rows[$].typed_result = '{present: p, occupied_bins: occ, unique_items: uniq};
   endfunction

   function automatic void add_write(input int unsigned idx, input logic [31:0] value);
      add_request(MODE_INSERT, '0);
      directed_rows[$].is_write  = 1'b1;
      directed_rows[$].reg_idx   = idx;
      directed_rows[$].reg_value = value;
   endfunction

   // Response side: check every claimed response, then pick ready for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("response with none pending", '0, '0);
         end else begin
            response_want = pending_results.pop_front();
            if (rsp_bus.present !== response_want.present)
               note_mismatch("present", response_want.present, rsp_bus.present);
            if (rsp_bus.occupied_bins !== response_want.occupied_bins)
               note_mismatch("occupied_bins", response_want.occupied_bins,
                             rsp_bus.occupied_bins);
            if (rsp_bus.unique_items !== response_want.unique_items)
               note_mismatch("unique_items", response_want.unique_items,
                             rsp_bus.unique_items);
         end
      end
      // Start a long hold-off when the sender asks for one; it keeps offering meanwhile.
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, MAX_BURST) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mode_type    m;
      logic [63:0] h;
      logic [CSR_DATA_W-1:0] reg_value;
      int unsigned pick;

      // Drive every input to a known value from time zero.
      clock              = 1'b0;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_INSERT;
      req_bus.hash_value = '0;
      rsp_bus.ready      = 1'b0;
      mismatch_count     = 0;
      idle_cycles        = 0;
      hold_requests      = 0;
      hold_served        = 0;
      hold_left          = 0;
      stall_left         = 0;
      quiet              = 1'b0;
      occupied_shadow    = '0;
      unique_shadow      = '0;
      table_count_shadow   = TABLE_COUNT_RESET;
      table_size_shadow[0] = SIZE_ZERO_RESET;
      table_size_shadow[1] = SIZE_ONE_RESET;
      table_size_shadow[2] = SIZE_TWO_RESET;
      table_size_shadow[3] = SIZE_THREE_RESET;

      // Directed rows: fresh filter, then each register at its extremes.
      add_checked(MODE_QUERY,  64'd0, 1'b0, 17'd0, 32'd0);
      add_checked(MODE_INSERT, 64'd0, 1'b0, 17'd1, 32'd1);
      add_checked(MODE_QUERY,  64'd0, 1'b1, 17'd1, 32'd1);
      add_checked(MODE_INSERT, 64'd0, 1'b1, 17'd1, 32'd1);
      add_request(MODE_INSERT, '1);
      add_request(MODE_QUERY,  '1);
      add_request(MODE_INSERT, 64'd65521);
      add_request(MODE_INSERT, 64'h8000_0000_0000_0000);
      add_request(MODE_QUERY,  64'd1);
      // Single table of one bin: every hash lands on bin zero.
      add_write(REG_TABLE_COUNT, 32'd1);
      add_write(REG_SIZE_ZERO,   32'd1);
      add_request(MODE_INSERT, 64'h0123_4567_89AB_CDEF);
      add_request(MODE_QUERY,  64'hFEDC_BA98_7654_3210);
      // Zero size acts as one bin, zero count as one table.
      add_write(REG_SIZE_ZERO,   32'd0);
      add_write(REG_TABLE_COUNT, 32'd0);
      add_request(MODE_INSERT, 64'h5555_5555_5555_5555);
      add_request(MODE_QUERY,  64'hAAAA_AAAA_AAAA_AAAA);
      // Count above the table number, sizes at and above the bin limit.
      add_write(REG_TABLE_COUNT,  32'd7);
      add_write(REG_SIZE_ZERO,    32'd65536);
      add_write(REG_SIZE_ONE,     32'h1_FFFF);
      add_write(REG_SIZE_TWO,     32'h1_0001);
      add_write(REG_SIZE_THREE,   32'd65536);
      add_request(MODE_INSERT, 64'h0000_0000_0000_FFFF);
      add_request(MODE_INSERT, 64'h0000_0000_0001_0000);
      add_request(MODE_QUERY,  64'h0000_0001_0000_FFFF);
      add_request(MODE_INSERT, '1);
      // Writes past the register list must leave everything alone.
      add_write(REG_TABLE_COUNT,  32'd5);
      add_write(REG_BEYOND_LAST,  32'hFFFF_FFFF);
      add_write(REG_SIZE_ZERO,    32'd2);
      add_write(REG_SIZE_ONE,     32'd3);
      add_write(REG_SIZE_TWO,     32'd5);
      add_write(REG_SIZE_THREE,   32'd7);
      add_request(MODE_INSERT, 64'd6);
      add_request(MODE_QUERY,  64'd210);
      add_request(MODE_INSERT, 64'd209);
      add_request(MODE_QUERY,  '1);
      add_write(REG_TABLE_COUNT,  32'd2);
      add_request(MODE_QUERY,  64'd1);
      add_request(MODE_INSERT, 64'd3);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Check reset values of the register file; the clearing pass accepts reads.
      for (int r = 0; r < REG_COUNT; r++) begin
         csr_read(r, reg_value);
         @(posedge clock);
         if (r == REG_TABLE_COUNT) begin
            if (reg_value[TCOUNT_W-1:0] !== table_count_shadow)
               note_mismatch("reset table_count", table_count_shadow, reg_value);
         end else if (reg_value[SIZE_W-1:0] !== table_size_shadow[r - 1]) begin
            note_mismatch($sformatf("reset size %0d", r - 1), table_size_shadow[r - 1],
                          reg_value);
         end
      end

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            drain_filter();
            csr_write(directed_rows[i].reg_idx, directed_rows[i].reg_value);
         end else begin
            send_request(directed_rows[i].mode, directed_rows[i].hash,
                         directed_rows[i].typed, directed_rows[i].typed_result);
         end
      end

      // Random phases, each under its own configuration written while idle.
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         drain_filter();
         if (phase == 0) begin
            csr_write(REG_TABLE_COUNT, CSR_DATA_W'(TABLE_COUNT_RESET));
            csr_write(REG_SIZE_ZERO,   CSR_DATA_W'(SIZE_ZERO_RESET));
            csr_write(REG_SIZE_ONE,    CSR_DATA_W'(SIZE_ONE_RESET));
            csr_write(REG_SIZE_TWO,    CSR_DATA_W'(SIZE_TWO_RESET));
            csr_write(REG_SIZE_THREE,  CSR_DATA_W'(SIZE_THREE_RESET));
         end else begin
            csr_write(REG_TABLE_COUNT, $urandom_range(0, 7));
            for (int s = 0; s < SIZE_SLOTS; s++) begin
               // Favor small tables so bins fill up and queries hit.
               case ($urandom_range(0, 9))
                  0:       reg_value = 0;
                  1:       reg_value = 1;
                  2, 3, 4: reg_value = $urandom_range(2, 200);
                  5, 6:    reg_value = $urandom_range(60000, 65536);
                  7:       reg_value = 65536;
                  8:       reg_value = $urandom_range(65537, 131071);
                  default: reg_value = $urandom_range(0, 131071);
               endcase
               csr_write(REG_SIZE_ZERO + s, reg_value);
            end
         end
         if (phase == HOLD_PHASE) hold_requests++;
         if (phase == RAND_PHASES - 1) quiet = 1'b1;

         repeat (PHASE_REQUESTS) begin
            pick = $urandom_range(0, 9);
            m = (pick inside {[4:6], 8}) ? MODE_QUERY : MODE_INSERT;
            h = {$urandom, $urandom};
            if ((pick inside {[4:7]}) && seen_hashes.size() != 0)
               h = seen_hashes[$urandom_range(0, seen_hashes.size() - 1)];
            if (pick == 9) begin
               m = mode_type'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0:       h = '0;
                  1:       h = '1;
                  2:       h = 64'd1 << $urandom_range(0, 63);
                  default: h = ~(64'd1 << $urandom_range(0, 63));
               endcase
            end
            send_request(m, h, 1'b0, '0);
         end
      end

      // Wait for the last responses, then let the pipeline settle.
      drain_filter();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
